FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the boost group tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, ignored while reset is held.
`define BGMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define BGMT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/bgmt_pkg.sv
// ----------------------------------------------------------------------------
// bgmt_pkg
// Types and constants of the per-CPU boost group maximum tracker.
// ----------------------------------------------------------------------------
package bgmt_pkg;

    localparam int CPUS       = 8;
    localparam int GROUPS     = 4;
    localparam int COUNT_BITS = 16;

    localparam int FUNC_BITS  = 3;
    localparam int CPU_BITS   = 3;
    localparam int GRP_BITS   = 2;
    localparam int BOOST_BITS = 7;

    localparam logic [BOOST_BITS-1:0] BOOST_LIMIT = BOOST_BITS'(100);
    localparam logic [CPU_BITS-1:0]   CPU_LAST    = CPU_BITS'(CPUS - 1);

    // One memory row holds the task counts of all groups on one CPU.
    typedef logic [GROUPS-1:0][COUNT_BITS-1:0] t_row;
    typedef logic [GROUPS-1:0][BOOST_BITS-1:0] t_boosts;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_ENQ  = 3'd0,
        FN_DEQ  = 3'd1,
        FN_SET  = 3'd2,
        FN_CLR  = 3'd3,
        FN_READ = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLR,
        ST_CALC,
        ST_OUT
    } t_state;

endpackage

FILE: rtl/core/boost_group_max_tracker_unit.sv
// Sequence: enqueue, dequeue, set and read pass from ST_IDLE through ST_CALC
// to ST_OUT; a clear first sweeps all rows in ST_CLR. ST_OUT waits while a
// held result is not taken. s_axis_tready is high only in ST_IDLE, so one
// transaction is handled at a time; reads of the count memory are registered.
// Reset: i_rst_n clears the per-row valid bits, so every count reads as zero
// at once; boosts are cleared too and there is no clearing pass.
// ----------------------------------------------------------------------------
// boost_group_max_tracker_unit
// Per-CPU runnable task counts per boost group and the resulting CPU boost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module boost_group_max_tracker_unit
    import bgmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cpu_index[2:0], group_index[4:3], boost_setting[11:5],
    //        task_exiting[12], zero fill [15:13]
    input  logic [15:0] s_axis_tdata,
    // tuser: func[2:0]
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: cpu_boost[6:0], zero fill [7]
    output logic [7:0]  m_axis_tdata,
    // tuser: status[0]
    output logic        m_axis_tuser
);

    // ------------------------------------------------------------------------
    // Handshakes and the accepted transaction
    // ------------------------------------------------------------------------
    t_state r_state, n_state;

    logic s_fire;
    logic m_fire;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = m_axis_tvalid && m_axis_tready;

    // The fields of the accepted transaction are held for the whole operation.
    logic [FUNC_BITS-1:0]  r_func;
    logic [CPU_BITS-1:0]   r_cpu;
    logic [GRP_BITS-1:0]   r_grp;
    logic [BOOST_BITS-1:0] r_bval;
    logic                  r_exit;

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_func <= s_axis_tuser;
            r_cpu  <= s_axis_tdata[2:0];
            r_grp  <= s_axis_tdata[4:3];
            r_bval <= s_axis_tdata[11:5];
            r_exit <= s_axis_tdata[12];
        end
    end

    // ------------------------------------------------------------------------
    // Count memory: one row per CPU, one count field per group. A row that has
    // never been written since reset has its valid bit low and reads as zero.
    // ------------------------------------------------------------------------
    t_row                r_mem [CPUS];
    logic [CPUS-1:0]     r_row_valid;
    t_row                r_rdata;
    logic                r_rd_valid;

    logic                mem_re;
    logic [CPU_BITS-1:0] mem_ra;
    logic                mem_we;
    logic [CPU_BITS-1:0] mem_wa;
    t_row                mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_row_valid[mem_wa] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_valid <= r_row_valid[mem_ra];
            end
        end
    end

    t_row rd_row;
    assign rd_row = r_rd_valid ? r_rdata : '0;

    // ------------------------------------------------------------------------
    // Boost registers, sweep counter, captured row and result hold
    // ------------------------------------------------------------------------
    t_boosts               r_boost, n_boost;
    logic [CPU_BITS-1:0]   r_sweep, n_sweep;
    t_row                  r_hit_row, n_hit_row;
    logic [BOOST_BITS-1:0] r_res_boost, n_res_boost;
    logic                  r_res_status, n_res_status;

    logic [BOOST_BITS-1:0] r_out_boost, n_out_boost;
    logic                  r_out_status, n_out_status;
    logic                  r_out_valid, n_out_valid;

    // Row that the CPU boost is taken from once the update is done.
    t_row                  calc_row;
    logic [BOOST_BITS-1:0] calc_boost;

    bgmt_boost_max u_boost_max (
        .i_row   (calc_row),
        .i_boost (n_boost),
        .o_boost (calc_boost)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_boost     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_boost     <= n_boost;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep      <= n_sweep;
        r_hit_row    <= n_hit_row;
        r_res_boost  <= n_res_boost;
        r_res_status <= n_res_status;
        r_out_boost  <= n_out_boost;
        r_out_status <= n_out_status;
    end

    // ------------------------------------------------------------------------
    // Sequencer. A clear sweeps all rows, reading the next row while the
    // current one is written back, so a read never meets a write to its row.
    // Others read the addressed row; non-exiting enq/deq write it back updated.
    // ------------------------------------------------------------------------
    logic [COUNT_BITS-1:0] cnt;
    logic                  is_cnt_op;

    always_comb begin
        n_state      = r_state;
        n_boost      = r_boost;
        n_sweep      = r_sweep;
        n_hit_row    = r_hit_row;
        n_res_boost  = r_res_boost;
        n_res_status = r_res_status;
        n_out_boost  = r_out_boost;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !m_fire;
        mem_re       = 1'b0;
        mem_ra       = '0;
        mem_we       = 1'b0;
        mem_wa       = r_cpu;
        mem_wd       = rd_row;
        calc_row     = rd_row;
        cnt          = rd_row[r_grp];
        is_cnt_op    = ((r_func == FN_ENQ) || (r_func == FN_DEQ)) && !r_exit;

        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    mem_re  = 1'b1;
                    n_sweep = '0;
                    if (s_axis_tuser == FN_CLR) begin
                        mem_ra  = '0;
                        n_state = ST_CLR;
                    end else begin
                        mem_ra  = s_axis_tdata[2:0];
                        n_state = ST_CALC;
                    end
                end
            end

            ST_CLR: begin
                mem_we         = 1'b1;
                mem_wa         = r_sweep;
                mem_wd[r_grp]  = '0;
                if (r_sweep == r_cpu) begin
                    n_hit_row = mem_wd;
                end
                if (r_sweep == CPU_LAST) begin
                    n_state = ST_CALC;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_sweep + 1'b1;
                    n_sweep = r_sweep + 1'b1;
                end
            end

            ST_CALC: begin
                n_res_status = 1'b0;
                case (r_func)
                    FN_ENQ: begin
                        if (cnt != '1) begin
                            cnt = cnt + 1'b1;
                        end
                    end
                    FN_DEQ: begin
                        if (cnt != '0) begin
                            cnt = cnt - 1'b1;
                        end
                    end
                    FN_SET: begin
                        if (r_bval > BOOST_LIMIT) begin
                            n_res_status = 1'b1;
                        end else begin
                            n_boost[r_grp] = r_bval;
                        end
                    end
                    FN_CLR: begin
                        n_boost[r_grp] = '0;
                    end
                    default: begin
                        // Read and the unused codes leave the state alone.
                    end
                endcase
                mem_wd[r_grp] = cnt;
                mem_we        = is_cnt_op;
                if (r_func == FN_CLR) begin
                    calc_row = r_hit_row;
                end else if (is_cnt_op) begin
                    calc_row = mem_wd;
                end
                n_res_boost = calc_boost;
                n_state     = ST_OUT;
            end

            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_boost  = r_res_boost;
                    n_out_status = r_res_status;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_boost};
    assign m_axis_tuser  = r_out_status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `BGMT_ASSERT(a_no_rw_collision, (mem_we && mem_re) |-> (mem_wa != mem_ra), "row read and written in the same cycle")
    `BGMT_ASSERT(a_boost_in_range, m_axis_tvalid |-> (m_axis_tdata[6:0] <= BOOST_LIMIT), "reported boost above the limit")
    `BGMT_ASSERT(a_accept_leaves_idle, s_fire |=> (r_state != ST_IDLE), "accepted transaction left no work")
    `BGMT_ASSERT(a_clr_write_only, (r_state == ST_CLR) |-> (mem_we && (mem_wa == r_sweep)), "sweep skipped a row")

endmodule

FILE: rtl/core/bgmt_boost_max.sv
// ----------------------------------------------------------------------------
// bgmt_boost_max
// Maximum boost of one CPU: the root group plus every group with tasks there.
// ----------------------------------------------------------------------------
module bgmt_boost_max
    import bgmt_pkg::*;
(
    input  t_row                  i_row,
    input  t_boosts               i_boost,
    output logic [BOOST_BITS-1:0] o_boost
);

    always_comb begin
        o_boost = i_boost[0];
        // The root group is always active; the others count only with tasks.
        for (int g = 1; g < GROUPS; g++) begin
            if ((i_row[g] != '0) && (i_boost[g] > o_boost)) begin
                o_boost = i_boost[g];
            end
        end
    end

endmodule
